@@ hdl/dual_encoder_hysteresis_tick_counter_macros.svh @@
// Assertion helpers used by the checker file.
`ifndef DUAL_ENCODER_HYSTERESIS_TICK_COUNTER_MACROS_SVH
`define DUAL_ENCODER_HYSTERESIS_TICK_COUNTER_MACROS_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define DEHTC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dehtc checker: same-cycle property failed");

// Check that the consequent holds in the cycle after the antecedent.
`define DEHTC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dehtc checker: next-cycle property failed");

`endif

@@ hdl/dehtc_pkg.sv @@
`default_nettype none

package dehtc_pkg;

    localparam int unsigned SampleWidth = 10;
    localparam int unsigned CountWidth  = 16;

    typedef logic [SampleWidth-1:0] sample_t;
    typedef logic [CountWidth-1:0]  count_t;

    // Sequencer steps; the spare step is never entered from reset.
    typedef enum logic [1:0] {
        CH_INNER   = 2'd0,
        CH_WALL    = 2'd1,
        CH_BATTERY = 2'd2,
        CH_SPARE   = 2'd3
    } chan_t;

    // Register indexes on the configuration port.
    typedef enum logic [1:0] {
        REG_INNER_HIGH = 2'd0,
        REG_INNER_LOW  = 2'd1,
        REG_WALL_HIGH  = 2'd2,
        REG_WALL_LOW   = 2'd3
    } reg_idx_t;

    localparam sample_t HighThresholdReset = 10'd700;
    localparam sample_t LowThresholdReset  = 10'd300;

    typedef struct packed {
        sample_t high;
        sample_t low;
    } thresh_t;

    typedef struct packed {
        thresh_t inner;
        thresh_t wall;
    } cfg_t;

    typedef struct packed {
        chan_t   channel;
        logic    inner_level;
        logic    wall_level;
        count_t  inner_ticks;
        count_t  wall_ticks;
        count_t  tick_difference;
        count_t  accumulated_error;
        sample_t battery_level;
    } result_t;

endpackage

`default_nettype wire

@@ hdl/dehtc_if.sv @@
`default_nettype none

interface dehtc_sample_if;
    import dehtc_pkg::*;

    logic    valid;
    logic    ready;
    sample_t sample;

    modport source (output valid, output sample, input ready);
    modport sink (input valid, input sample, output ready);
endinterface

interface dehtc_result_if;
    import dehtc_pkg::*;

    logic               valid;
    logic               ready;
    logic [1:0]         sampled_channel;
    logic               inner_level;
    logic               wall_level;
    logic [15:0]        inner_ticks;
    logic [15:0]        wall_ticks;
    logic signed [15:0] tick_difference;
    logic signed [15:0] accumulated_error;
    logic [9:0]         battery_level;

    modport source (
        output valid, output sampled_channel, output inner_level, output wall_level,
        output inner_ticks, output wall_ticks, output tick_difference,
        output accumulated_error, output battery_level, input ready
    );
    modport sink (
        input valid, input sampled_channel, input inner_level, input wall_level,
        input inner_ticks, input wall_ticks, input tick_difference,
        input accumulated_error, input battery_level, output ready
    );
endinterface

`default_nettype wire

@@ hdl/dehtc_cfg.sv @@
`default_nettype none

module dehtc_cfg (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          psel,
    input  wire logic          penable,
    input  wire logic          pwrite,
    input  wire logic [3:0]    paddr,
    input  wire logic [31:0]   pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    output dehtc_pkg::cfg_t    cfg
);
    import dehtc_pkg::*;

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    reg_idx_t idx;
    logic     wr_en;
    sample_t  wdata;
    sample_t  rdata;

    assign pready = 1'b1;
    assign idx    = reg_idx_t'(paddr[3:2]);
    assign wr_en  = psel && penable && pwrite && pready;
    assign wdata  = pwdata[SampleWidth-1:0];

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (idx)
                REG_INNER_HIGH: cfg_next.inner.high = wdata;
                REG_INNER_LOW:  cfg_next.inner.low  = wdata;
                REG_WALL_HIGH:  cfg_next.wall.high  = wdata;
                REG_WALL_LOW:   cfg_next.wall.low   = wdata;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_INNER_HIGH: rdata = cfg_reg.inner.high;
            REG_INNER_LOW:  rdata = cfg_reg.inner.low;
            REG_WALL_HIGH:  rdata = cfg_reg.wall.high;
            REG_WALL_LOW:   rdata = cfg_reg.wall.low;
        endcase
    end

    assign prdata = {{(32-SampleWidth){1'b0}}, rdata};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.inner.high <= HighThresholdReset;
            cfg_reg.inner.low  <= LowThresholdReset;
            cfg_reg.wall.high  <= HighThresholdReset;
            cfg_reg.wall.low   <= LowThresholdReset;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

@@ hdl/dehtc_hyst.sv @@
`default_nettype none

module dehtc_hyst (
    input  wire dehtc_pkg::sample_t level_in,
    input  wire dehtc_pkg::thresh_t thresh,
    input  wire logic               level,
    output logic                    level_new,
    output logic                    toggle
);
    import dehtc_pkg::*;

    logic set_hit;
    logic clr_hit;

    // Set test wins; clear is only looked at when set does not fire.
    assign set_hit   = (level_in >= thresh.high) && !level;
    assign clr_hit   = !set_hit && (level_in <= thresh.low) && level;
    assign toggle    = set_hit || clr_hit;
    assign level_new = toggle ? !level : level;

endmodule

`default_nettype wire

@@ hdl/dual_encoder_hysteresis_tick_counter.sv @@
`default_nettype none

// Dual wheel-encoder hysteresis tick counter. Each item on the samples channel
// is one 10-bit converter result; a three-step sequencer files it as the inner
// wheel sensor, the wall wheel sensor, then the battery, and repeats from reset.
// After each wheel sample both wheels run a set-first hysteresis comparator on
// their latest stored samples, every level change bumps that wheel's wrapping
// 16-bit tick count, and the inner-minus-wall difference is added into a
// wrapping 16-bit error sum. Battery samples only refresh battery_level. Every
// sample yields exactly one item on the results channel. Throughput is one item
// per clock while results.ready holds; each sample passes the input register, then the result register.
// The recurrence on the sequencer, levels, counts and error sum closes in the
// single stage between those two registers, which is what sets the rate.
// samples.ready looks through to results.ready combinationally, so while a
// finished result waits the block takes an item only into an empty input
// register and holds it there until the result drains. Thresholds are written
// through the APB port at byte addresses 0, 4, 8 and 12 (inner high, inner low,
// wall high, wall low); write them only while the block is idle.

module dual_encoder_hysteresis_tick_counter (
    input  wire logic        clk,
    input  wire logic        rst_n,
    dehtc_sample_if.sink     samples,
    dehtc_result_if.source   results,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import dehtc_pkg::*;

    cfg_t    cfg;

    // Input register
    logic    in_valid_reg;
    logic    in_valid_next;
    sample_t in_sample_reg;

    // Architectural state
    chan_t   chan_reg;
    chan_t   chan_next;
    sample_t inner_sample_reg;
    sample_t inner_sample_next;
    sample_t wall_sample_reg;
    sample_t wall_sample_next;
    sample_t battery_reg;
    sample_t battery_next;
    logic    inner_level_reg;
    logic    inner_level_next;
    logic    wall_level_reg;
    logic    wall_level_next;
    count_t  inner_count_reg;
    count_t  inner_count_next;
    count_t  wall_count_reg;
    count_t  wall_count_next;
    count_t  error_reg;
    count_t  error_next;

    // Result register
    logic    out_valid_reg;
    logic    out_valid_next;
    result_t result_reg;
    result_t result_next;

    logic    advance;
    logic    encoder;
    logic    inner_lvl_cmp;
    logic    inner_tog;
    logic    wall_lvl_cmp;
    logic    wall_tog;
    count_t  diff;

    dehtc_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Advance the held item whenever the result register is free or draining.
    assign advance       = in_valid_reg && (!out_valid_reg || results.ready);
    assign samples.ready = !in_valid_reg || advance;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (samples.valid && samples.ready)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end
    end

    // Route the sample to its channel and step the sequencer.
    always_comb
    begin
        inner_sample_next = inner_sample_reg;
        wall_sample_next  = wall_sample_reg;
        battery_next      = battery_reg;
        encoder           = 1'b0;
        chan_next         = CH_INNER;
        unique case (chan_reg)
            CH_INNER:
            begin
                inner_sample_next = in_sample_reg;
                encoder           = 1'b1;
                chan_next         = CH_WALL;
            end
            CH_WALL:
            begin
                wall_sample_next = in_sample_reg;
                encoder          = 1'b1;
                chan_next        = CH_BATTERY;
            end
            CH_BATTERY:
            begin
                battery_next = in_sample_reg;
                chan_next    = CH_INNER;
            end
            CH_SPARE:
            begin
                chan_next = CH_INNER;
            end
        endcase
    end

    dehtc_hyst u_hyst_inner (
        .level_in  (inner_sample_next),
        .thresh    (cfg.inner),
        .level     (inner_level_reg),
        .level_new (inner_lvl_cmp),
        .toggle    (inner_tog)
    );

    dehtc_hyst u_hyst_wall (
        .level_in  (wall_sample_next),
        .thresh    (cfg.wall),
        .level     (wall_level_reg),
        .level_new (wall_lvl_cmp),
        .toggle    (wall_tog)
    );

    // Comparators only take effect on wheel samples.
    always_comb
    begin
        inner_level_next = inner_level_reg;
        wall_level_next  = wall_level_reg;
        inner_count_next = inner_count_reg;
        wall_count_next  = wall_count_reg;
        if (encoder)
        begin
            inner_level_next = inner_lvl_cmp;
            wall_level_next  = wall_lvl_cmp;
            inner_count_next = inner_count_reg + count_t'(inner_tog);
            wall_count_next  = wall_count_reg + count_t'(wall_tog);
        end
        diff       = inner_count_next - wall_count_next;
        error_next = encoder ? (error_reg + diff) : error_reg;
    end

    always_comb
    begin
        result_next.channel           = chan_reg;
        result_next.inner_level       = inner_level_next;
        result_next.wall_level        = wall_level_next;
        result_next.inner_ticks       = inner_count_next;
        result_next.wall_ticks        = wall_count_next;
        result_next.tick_difference   = diff;
        result_next.accumulated_error = error_next;
        result_next.battery_level     = battery_next;
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (results.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            chan_reg         <= CH_INNER;
            inner_sample_reg <= '0;
            wall_sample_reg  <= '0;
            battery_reg      <= '0;
            inner_level_reg  <= 1'b0;
            wall_level_reg   <= 1'b0;
            inner_count_reg  <= '0;
            wall_count_reg   <= '0;
            error_reg        <= '0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance)
            begin
                chan_reg         <= chan_next;
                inner_sample_reg <= inner_sample_next;
                wall_sample_reg  <= wall_sample_next;
                battery_reg      <= battery_next;
                inner_level_reg  <= inner_level_next;
                wall_level_reg   <= wall_level_next;
                inner_count_reg  <= inner_count_next;
                wall_count_reg   <= wall_count_next;
                error_reg        <= error_next;
            end
        end
    end

    // Payload registers: the input payload loads on capture, the result payload on advance.
    always_ff @(posedge clk)
    begin
        if (samples.valid && samples.ready)
        begin
            in_sample_reg <= samples.sample;
        end
        if (advance)
        begin
            result_reg <= result_next;
        end
    end

    assign results.valid             = out_valid_reg;
    assign results.sampled_channel   = result_reg.channel;
    assign results.inner_level       = result_reg.inner_level;
    assign results.wall_level        = result_reg.wall_level;
    assign results.inner_ticks       = result_reg.inner_ticks;
    assign results.wall_ticks        = result_reg.wall_ticks;
    assign results.tick_difference   = result_reg.tick_difference;
    assign results.accumulated_error = result_reg.accumulated_error;
    assign results.battery_level     = result_reg.battery_level;

endmodule

`default_nettype wire

@@ hdl/dehtc_checker.sv @@
`default_nettype none

`include "dual_encoder_hysteresis_tick_counter_macros.svh"

module dehtc_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        res_valid,
    input wire logic        res_ready,
    input wire logic [1:0]  res_channel,
    input wire logic [15:0] res_inner_ticks,
    input wire logic [15:0] res_wall_ticks,
    input wire logic [15:0] res_diff,
    input wire logic [15:0] res_error
);
    import dehtc_pkg::*;

    // Stalled result holds its payload.
    `DEHTC_ASSERT_NEXT(a_stall_hold, res_valid && !res_ready, res_valid && $stable(res_channel) && $stable(res_error))

    // The spare sequencer step never shows up.
    `DEHTC_ASSERT_NOW(a_no_spare, res_valid, res_channel != CH_SPARE)

    // Difference always matches the reported tick counts.
    `DEHTC_ASSERT_NOW(a_diff, res_valid, res_diff == 16'(res_inner_ticks - res_wall_ticks))

    // Back-to-back results step from inner to wall, following the inner, wall, battery order.
    `DEHTC_ASSERT_NEXT(a_order, res_valid && res_ready && (res_channel == CH_INNER), !res_valid || (res_channel == CH_WALL))

endmodule

bind dual_encoder_hysteresis_tick_counter dehtc_checker u_dehtc_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .res_valid       (results.valid),
    .res_ready       (results.ready),
    .res_channel     (results.sampled_channel),
    .res_inner_ticks (results.inner_ticks),
    .res_wall_ticks  (results.wall_ticks),
    .res_diff        (results.tick_difference),
    .res_error       (results.accumulated_error)
);

`default_nettype wire
